@@ hw/rtl/dflt_pkg.sv @@
// Shared types, codes and constants of the deduplicating flow log table.
package dflt_pkg;

    localparam int DFLT_DEPTH = 64;

    localparam logic [1:0] REQ_ADD   = 2'd0;
    localparam logic [1:0] REQ_READ  = 2'd1;
    localparam logic [1:0] REQ_CLEAR = 2'd2;

    typedef enum logic [1:0] {
        ST_DONE   = 2'd0,
        ST_MERGED = 2'd1,
        ST_FULL   = 2'd2,
        ST_RANGE  = 2'd3
    } t_status;

    typedef struct packed {
        logic [1:0]        req_type;
        logic [31:0]       pkt_timestamp;
        logic [7:0]        pkt_protocol;
        logic [7:0]        pkt_action;
        logic [7:0]        pkt_hook;
        logic [31:0]       pkt_src_ip;
        logic [31:0]       pkt_dst_ip;
        logic [15:0]       pkt_src_port;
        logic [15:0]       pkt_dst_port;
        logic signed [7:0] pkt_reason;
        logic [5:0]        read_index;
    } t_req;

    typedef struct packed {
        t_status           status;
        logic [6:0]        entries_in_use;
        logic [31:0]       out_timestamp;
        logic [7:0]        out_protocol;
        logic [7:0]        out_action;
        logic [7:0]        out_hook;
        logic [31:0]       out_src_ip;
        logic [31:0]       out_dst_ip;
        logic [15:0]       out_src_port;
        logic [15:0]       out_dst_port;
        logic signed [7:0] out_reason;
        logic [31:0]       out_count;
    } t_rsp;

    // Flow key: every packet field but the timestamp.
    typedef struct packed {
        logic [31:0] src_ip;
        logic [31:0] dst_ip;
        logic [15:0] sport;
        logic [15:0] dport;
        logic [7:0]  protocol;
        logic [7:0]  action;
        logic [7:0]  hook;
        logic [7:0]  reason;
    } t_key;

    typedef struct packed {
        t_key        key;
        logic [31:0] tstamp;
        logic [31:0] hits;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

endpackage

@@ hw/rtl/dflt_if.sv @@
// Request and response channel interfaces of the flow log table.
interface dflt_req_if import dflt_pkg::*; ();
    logic valid;
    logic ready;
    t_req payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface dflt_rsp_if import dflt_pkg::*; ();
    logic valid;
    logic ready;
    t_rsp payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

@@ hw/rtl/dedup_flow_log_table_unit.sv @@
// Top level of the deduplicating flow log table: sequencer, entry RAM, compare unit.
//
//  channel  | dir | handshake   | payload
//  ---------+-----+-------------+--------------------------------------------
//  i_req    | in  | valid/ready | request type, packet fields, read index
//  o_rsp    | out | valid/ready | status, entry count, entry fields, hit count
//
// An add walks the stored entries through one RAM read port, one per cycle, into a
// single compare unit; a hit ends the walk early. A read fetches its entry through the
// same port; a clear, an unknown request or an out-of-range read does not use the RAM.
// Input is ready only in idle; a finished result waits in the done state while the
// response register is full.
// Reset empties the table at once: RAM contents are never read at or above the fill count.
module dedup_flow_log_table_unit import dflt_pkg::*; #(
    parameter int TABLE_DEPTH = DFLT_DEPTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    dflt_req_if.sink   i_req,
    dflt_rsp_if.source o_rsp
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_SCAN = 4'b0010,
        S_READ = 4'b0100,
        S_DONE = 4'b1000
    } t_state;

    t_state        r_state, n_state;
    logic [CW-1:0] r_used, n_used;
    logic [CW-1:0] r_ptr, n_ptr;
    logic          r_rd_vld, n_rd_vld;
    logic [AW-1:0] r_rd_idx, n_rd_idx;
    t_key          r_key, n_key;
    logic [31:0]   r_ts, n_ts;
    t_rsp          r_pend, n_pend;
    t_rsp          r_out, n_out;
    logic          r_out_vld, n_out_vld;

    logic                 wr_en;
    logic [AW-1:0]        wr_addr;
    t_entry               wr_ent;
    logic [AW-1:0]        rd_addr;
    logic [ENTRY_W-1:0]   rd_data;
    t_entry               rd_ent;
    logic                 m_hit;
    logic [31:0]          m_hits_inc;
    logic                 issue_en;
    logic                 idx_ge_used;
    logic [AW+5:0]        idx_ext;
    logic                 req_xfer;

    // Entry count as it appears on the 7-bit response field.
    function automatic logic [6:0] f_cnt7(input logic [CW-1:0] c);
        logic [CW+6:0] e;
        e = {7'b0, c};
        return e[6:0];
    endfunction

    assign req_xfer    = i_req.valid && i_req.ready;
    assign idx_ext     = {{AW{1'b0}}, i_req.payload.read_index};
    assign idx_ge_used = {{CW{1'b0}}, i_req.payload.read_index}
                         >= {6'b0, r_used};
    assign issue_en    = (r_state == S_SCAN) && (r_ptr < r_used);
    // Idle: fetch the entry a read asks for; scan: fetch the next candidate.
    assign rd_addr     = (r_state == S_IDLE) ? idx_ext[AW-1:0] : r_ptr[AW-1:0];
    assign rd_ent      = t_entry'(rd_data);

    dflt_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_ent),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    dflt_match u_match (
        .i_vld      (r_rd_vld && (r_state == S_SCAN)),
        .i_key      (r_key),
        .i_ent      (rd_ent),
        .o_hit      (m_hit),
        .o_hits_inc (m_hits_inc)
    );

    always_comb begin
        n_state   = r_state;
        n_used    = r_used;
        n_ptr     = r_ptr;
        n_rd_vld  = 1'b0;
        n_rd_idx  = r_ptr[AW-1:0];
        n_key     = r_key;
        n_ts      = r_ts;
        n_pend    = r_pend;
        n_out     = r_out;
        n_out_vld = r_out_vld;
        wr_en     = 1'b0;
        wr_addr   = r_used[AW-1:0];
        wr_ent    = '{key: r_key, tstamp: r_ts, hits: 32'd1};

        // Drop the response once its transfer completes.
        if (r_out_vld && o_rsp.ready) begin
            n_out_vld = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (req_xfer) begin
                    n_key  = '{src_ip:   i_req.payload.pkt_src_ip,
                               dst_ip:   i_req.payload.pkt_dst_ip,
                               sport:    i_req.payload.pkt_src_port,
                               dport:    i_req.payload.pkt_dst_port,
                               protocol: i_req.payload.pkt_protocol,
                               action:   i_req.payload.pkt_action,
                               hook:     i_req.payload.pkt_hook,
                               reason:   i_req.payload.pkt_reason};
                    n_ts   = i_req.payload.pkt_timestamp;
                    n_pend = '0;
                    n_pend.status         = ST_DONE;
                    n_pend.entries_in_use = f_cnt7(r_used);
                    unique case (i_req.payload.req_type)
                        REQ_ADD: begin
                            n_ptr   = '0;
                            n_state = S_SCAN;
                        end
                        REQ_READ: begin
                            if (idx_ge_used) begin
                                n_pend.status = ST_RANGE;
                                n_state       = S_DONE;
                            end else begin
                                n_state = S_READ;
                            end
                        end
                        REQ_CLEAR: begin
                            n_used                = '0;
                            n_pend.entries_in_use = 7'd0;
                            n_state               = S_DONE;
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                // Issue one read per cycle, compare the one issued last cycle.
                n_rd_vld = issue_en;
                n_ptr    = r_ptr + CW'(issue_en);
                if (m_hit) begin
                    wr_en            = 1'b1;
                    wr_addr          = r_rd_idx;
                    wr_ent           = rd_ent;
                    wr_ent.hits      = m_hits_inc;
                    n_pend.status    = ST_MERGED;
                    n_pend.out_count = m_hits_inc;
                    n_state          = S_DONE;
                end else if (!issue_en && !r_rd_vld) begin
                    if (r_used == CW'(TABLE_DEPTH)) begin
                        n_pend.status = ST_FULL;
                    end else begin
                        wr_en                 = 1'b1;
                        n_used                = r_used + CW'(1);
                        n_pend.out_count      = 32'd1;
                        n_pend.entries_in_use = f_cnt7(r_used + CW'(1));
                    end
                    n_state = S_DONE;
                end
            end
            S_READ: begin
                n_pend.out_timestamp = rd_ent.tstamp;
                n_pend.out_protocol  = rd_ent.key.protocol;
                n_pend.out_action    = rd_ent.key.action;
                n_pend.out_hook      = rd_ent.key.hook;
                n_pend.out_src_ip    = rd_ent.key.src_ip;
                n_pend.out_dst_ip    = rd_ent.key.dst_ip;
                n_pend.out_src_port  = rd_ent.key.sport;
                n_pend.out_dst_port  = rd_ent.key.dport;
                n_pend.out_reason    = rd_ent.key.reason;
                n_pend.out_count     = rd_ent.hits;
                n_state              = S_DONE;
            end
            S_DONE: begin
                // Hand the result over once the response register is free.
                if (!r_out_vld || o_rsp.ready) begin
                    n_out     = r_pend;
                    n_out_vld = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_used    <= '0;
            r_ptr     <= '0;
            r_rd_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_used    <= n_used;
            r_ptr     <= n_ptr;
            r_rd_vld  <= n_rd_vld;
            r_out_vld <= n_out_vld;
        end
        r_rd_idx <= n_rd_idx;
        r_key    <= n_key;
        r_ts     <= n_ts;
        r_pend   <= n_pend;
        r_out    <= n_out;
    end

    assign i_req.ready   = (r_state == S_IDLE);
    assign o_rsp.valid   = r_out_vld;
    assign o_rsp.payload = r_out;

endmodule

@@ hw/rtl/dflt_ram.sv @@
// Generic simple dual-port RAM with registered read data.
module dflt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ hw/rtl/dflt_match.sv @@
// Shared key compare unit with saturating hit-count increment.
module dflt_match import dflt_pkg::*; (
    input  logic        i_vld,
    input  t_key        i_key,
    input  t_entry      i_ent,
    output logic        o_hit,
    output logic [31:0] o_hits_inc
);

    assign o_hit      = i_vld && (i_ent.key == i_key);
    // Hold the count at its maximum instead of wrapping.
    assign o_hits_inc = (&i_ent.hits) ? i_ent.hits : i_ent.hits + 32'd1;

endmodule
